// File: rtl/core/bcg_pkg.sv
package bcg_pkg;

  // Pixel coordinate width.
  localparam int COORD_BITS = 12;

  // Image dimension register width.
  localparam int DIM_W = 13;

  // Packed color: four 8-bit channels.
  localparam int COLOR_W = 32;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = COLOR_W / CH_W;

  // Weights are unsigned 0.16 fixed point, with 1.0 itself needing a 17th bit.
  localparam int FRAC_W = 16;
  localparam int W_W    = FRAC_W + 1;
  localparam logic [W_W-1:0] ONE_Q16 = W_W'(1) << FRAC_W;

  // Horizontal blend is 8.16, vertical blend is 8.32.
  localparam int H_W   = CH_W + FRAC_W;
  localparam int MIX_W = H_W + FRAC_W;

  // Coordinate clamp compares in the wider of the two widths.
  localparam int CLAMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

  // Configuration register map.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_TOP_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_TOP_RIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_BOTTOM_LEFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_BOTTOM_RIGHT = 3'd5;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // One lane of the weight divider: partial remainder, quotient bits so far,
  // and the two cases that bypass the quotient (weight of one, weight of zero).
  typedef struct packed {
    logic [DIM_W-1:0]  rem;
    logic [FRAC_W-1:0] quo;
    logic              sat;
    logic              zero;
  } wdiv_t;

  typedef struct packed {
    wdiv_t x;
    wdiv_t y;
  } wpair_t;

endpackage

// File: rtl/core/bilinear_corner_gradient_top.sv
// Channel  Direction  Signals                                   Transfer
// -------  ---------  ----------------------------------------  ---------------------
// in       input      in_pixel_x, in_pixel_y                    in_valid & in_ready
// out      output     out_pixel_color                           out_valid & out_ready
// cfg      input      cfg_index, cfg_data                       cfg_valid & cfg_ready
//
// One pixel enters per cycle while the output is not held; each passes through
// one clamp stage, sixteen divider stages (one weight bit each, x and y in
// parallel), one horizontal blend, one vertical multiply and one round stage.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. When the output is held, the whole pipeline holds.
module bilinear_corner_gradient_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bcg_pkg::COORD_BITS-1:0]   in_pixel_x,
  input  logic [bcg_pkg::COORD_BITS-1:0]   in_pixel_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bcg_pkg::COLOR_W-1:0]      out_pixel_color,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcg_pkg::COLOR_W-1:0]      cfg_data
);
  import bcg_pkg::*;

  // Clamp the coordinate to the divisor and set up the first remainder.
  function automatic wdiv_t div_init(input logic [COORD_BITS-1:0] coord,
                                     input logic [DIM_W-1:0] dlim,
                                     input logic dzero);
    logic [CLAMP_W-1:0] c_ext;
    logic [CLAMP_W-1:0] d_ext;
    logic [CLAMP_W-1:0] c_min;
    wdiv_t s;
    c_ext  = CLAMP_W'(coord);
    d_ext  = CLAMP_W'(dlim);
    c_min  = (c_ext > d_ext) ? d_ext : c_ext;
    s.rem  = c_min[DIM_W-1:0];
    s.quo  = '0;
    s.sat  = (c_min == d_ext);
    s.zero = dzero;
    return s;
  endfunction

  // One restoring division step: produces one quotient bit.
  function automatic wdiv_t div_step(input wdiv_t s, input logic [DIM_W-1:0] dlim);
    logic [DIM_W:0] r2;
    logic [DIM_W:0] diff;
    wdiv_t o;
    o    = s;
    r2   = {s.rem, 1'b0};
    diff = r2 - {1'b0, dlim};
    if (r2 >= {1'b0, dlim}) begin
      o.rem = diff[DIM_W-1:0];
      o.quo = {s.quo[FRAC_W-2:0], 1'b1};
    end else begin
      o.rem = r2[DIM_W-1:0];
      o.quo = {s.quo[FRAC_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Final weight, with the zero and full-scale cases applied.
  function automatic logic [W_W-1:0] weight_of(input wdiv_t s);
    logic [W_W-1:0] w;
    if (s.zero) begin
      w = '0;
    end else if (s.sat) begin
      w = ONE_Q16;
    end else begin
      w = {1'b0, s.quo};
    end
    return w;
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [COLOR_W-1:0] tl_r;
  logic [COLOR_W-1:0] tr_r;
  logic [COLOR_W-1:0] bl_r;
  logic [COLOR_W-1:0] br_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      tl_r     <= '0;
      tr_r     <= '0;
      bl_r     <= '0;
      br_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:         width_r  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:        height_r <= cfg_data[DIM_W-1:0];
        REG_CORNER_TOP_LEFT:     tl_r     <= cfg_data;
        REG_CORNER_TOP_RIGHT:    tr_r     <= cfg_data;
        REG_CORNER_BOTTOM_LEFT:  bl_r     <= cfg_data;
        REG_CORNER_BOTTOM_RIGHT: br_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Divisors are dimension minus one; a dimension of zero or one forces weight 0.
  logic [DIM_W-1:0] dlim_x;
  logic [DIM_W-1:0] dlim_y;
  logic             dzero_x;
  logic             dzero_y;

  assign dlim_x  = width_r - DIM_W'(1);
  assign dlim_y  = height_r - DIM_W'(1);
  assign dzero_x = (width_r <= DIM_W'(1));
  assign dzero_y = (height_r <= DIM_W'(1));

  // The whole pipeline advances unless a finished result is held at the output.
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Clamp stage and divider stages: entry 0 is the clamp, entry k holds k bits.
  wpair_t          div_r   [0:FRAC_W];
  wpair_t          div_nxt [0:FRAC_W];
  logic [FRAC_W:0] dvld_r;

  always_comb begin
    div_nxt[0].x = div_init(in_pixel_x, dlim_x, dzero_x);
    div_nxt[0].y = div_init(in_pixel_y, dlim_y, dzero_y);
    for (int k = 1; k <= FRAC_W; k++) begin
      div_nxt[k].x = div_step(div_r[k-1].x, dlim_x);
      div_nxt[k].y = div_step(div_r[k-1].y, dlim_y);
    end
  end

  // Horizontal blend of the top and bottom corner pairs, per channel.
  logic [W_W-1:0] wx;
  logic [W_W-1:0] wy;
  logic [H_W-1:0] top_nxt [0:NUM_CH-1];
  logic [H_W-1:0] bot_nxt [0:NUM_CH-1];
  logic [H_W-1:0] top_r   [0:NUM_CH-1];
  logic [H_W-1:0] bot_r   [0:NUM_CH-1];
  logic [W_W-1:0] wy_r;
  logic           hvld_r;

  assign wx = weight_of(div_r[FRAC_W].x);
  assign wy = weight_of(div_r[FRAC_W].y);

  always_comb begin
    logic [H_W:0] sum_t;
    logic [H_W:0] sum_b;
    logic [W_W-1:0] omwx;
    omwx = ONE_Q16 - wx;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_t = (H_W+1)'(tl_r[ch*CH_W +: CH_W]) * (H_W+1)'(omwx)
            + (H_W+1)'(tr_r[ch*CH_W +: CH_W]) * (H_W+1)'(wx);
      sum_b = (H_W+1)'(bl_r[ch*CH_W +: CH_W]) * (H_W+1)'(omwx)
            + (H_W+1)'(br_r[ch*CH_W +: CH_W]) * (H_W+1)'(wx);
      top_nxt[ch] = sum_t[H_W-1:0];
      bot_nxt[ch] = sum_b[H_W-1:0];
    end
  end

  // Vertical products, per channel.
  logic [MIX_W-1:0] p0_nxt [0:NUM_CH-1];
  logic [MIX_W-1:0] p1_nxt [0:NUM_CH-1];
  logic [MIX_W-1:0] p0_r   [0:NUM_CH-1];
  logic [MIX_W-1:0] p1_r   [0:NUM_CH-1];
  logic             vvld_r;

  always_comb begin
    logic [MIX_W:0] prod0;
    logic [MIX_W:0] prod1;
    logic [W_W-1:0] omwy;
    omwy = ONE_Q16 - wy_r;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod0      = (MIX_W+1)'(top_r[ch]) * (MIX_W+1)'(omwy);
      prod1      = (MIX_W+1)'(bot_r[ch]) * (MIX_W+1)'(wy_r);
      p0_nxt[ch] = prod0[MIX_W-1:0];
      p1_nxt[ch] = prod1[MIX_W-1:0];
    end
  end

  // Sum, round half up and pack the channels.
  localparam logic [MIX_W:0] ROUND_HALF = (MIX_W+1)'(1) << (2*FRAC_W - 1);
  localparam int             RND_W      = MIX_W + 1 - 2*FRAC_W;

  logic [COLOR_W-1:0] color_nxt;
  logic [COLOR_W-1:0] color_r;

  always_comb begin
    logic [MIX_W:0]   acc;
    logic [RND_W-1:0] rnd;
    color_nxt = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = (MIX_W+1)'(p0_r[ch]) + (MIX_W+1)'(p1_r[ch]) + ROUND_HALF;
      rnd = acc[MIX_W:2*FRAC_W];
      if (rnd > RND_W'({CH_W{1'b1}})) begin
        color_nxt[ch*CH_W +: CH_W] = {CH_W{1'b1}};
      end else begin
        color_nxt[ch*CH_W +: CH_W] = rnd[CH_W-1:0];
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= FRAC_W; k++) begin
        div_r[k] <= div_nxt[k];
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
        top_r[ch] <= top_nxt[ch];
        bot_r[ch] <= bot_nxt[ch];
        p0_r[ch]  <= p0_nxt[ch];
        p1_r[ch]  <= p1_nxt[ch];
      end
      wy_r    <= wy;
      color_r <= color_nxt;
    end
  end

  // Valid bits travel alongside the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r      <= '0;
      hvld_r      <= 1'b0;
      vvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      dvld_r      <= {dvld_r[FRAC_W-1:0], in_valid};
      hvld_r      <= dvld_r[FRAC_W];
      vvld_r      <= hvld_r;
      out_valid_r <= vvld_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = color_r;

endmodule
